// ===== src/tkst_pkg.sv =====
`timescale 1ns / 1ps
package tkst_pkg;

  // table geometry and reset values
  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam logic [4:0]  KEEP_RESET      = 5'd10;
  localparam logic [23:0] TAG_RESET       = 24'h414141;

  // field widths
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned TAG_W   = 24;
  localparam int unsigned KEEP_W  = 5;

  // transaction kinds carried in tuser
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // per-cell load controls
  typedef struct packed {
    logic load_new;
    logic load_prev;
  } cell_ctrl_t;

endpackage

// ===== src/top_k_score_table_top.sv =====
`timescale 1ns / 1ps
// Sorted table of the best records (32-bit score plus three tag characters), highest
// score at rank 0, held in a row of MaxEntries cells. tuser selects add, query, read or
// no-op; every input transaction yields exactly one output transaction. One transaction
// is accepted per clock and its result appears in the output register on the next cycle;
// the input side keeps accepting while that register is free or being drained. The cycle
// is set by the per-cell score compare plus the insertion-point prefix chain that runs
// across all MaxEntries cells. keep_count (cfg port) bounds the active ranks: 0 acts as 1
// and values above MaxEntries act as MaxEntries. At reset every entry holds score 0 and
// tag "AAA", and keep_count is 10.
module top_k_score_table_top #(
  parameter int unsigned MaxEntries = tkst_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,      // keep_count
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // score[31:0], tag_first[39:32], tag_second[47:40], tag_third[55:48],
  // read_rank[59:56], zero pad[63:60]
  input  logic [63:0] s_axis_tdata_i,
  input  logic [1:0]  s_axis_tuser_i,   // opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // qualifies[0], placed[1], placed_rank[5:2], entry_score[37:6],
  // entry_tag_first[45:38], entry_tag_second[53:46], entry_tag_third[61:54],
  // best_score[93:62], zero pad[95:94]
  output logic [95:0] m_axis_tdata_o
);

  logic [tkst_pkg::KEEP_W-1:0] keep_q;
  logic                        in_fire;
  logic                        add_fire;
  tkst_pkg::op_e               op;
  logic [31:0]                 in_score;
  logic [23:0]                 in_tag;
  logic [3:0]                  in_rank;

  logic [31:0]          cell_score [MaxEntries];
  logic [23:0]          cell_tag   [MaxEntries];
  logic [MaxEntries-1:0] cell_le, cell_gt, active, le_v, hit_above, first;
  tkst_pkg::cell_ctrl_t cell_ctrl  [MaxEntries];

  logic        res_qual, res_placed;
  logic [3:0]  res_prank;
  logic [31:0] res_es, res_best, prank_full;
  logic [23:0] res_tag;

  logic        out_valid_q;
  logic [93:0] out_data_q;

  // input unpacking
  assign op       = tkst_pkg::op_e'(s_axis_tuser_i);
  assign in_score = s_axis_tdata_i[31:0];
  assign in_tag   = {s_axis_tdata_i[39:32], s_axis_tdata_i[47:40], s_axis_tdata_i[55:48]};
  assign in_rank  = s_axis_tdata_i[59:56];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign add_fire        = in_fire && (op == tkst_pkg::OP_ADD);

  // keep_count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= tkst_pkg::KEEP_RESET;
    end else if (cfg_we_i) begin
      keep_q <= cfg_wdata_i;
    end
  end

  // row of cells with insertion-point chain
  for (genvar i = 0; i < MaxEntries; i++) begin : g_cell
    assign active[i] = (i == 0) || ({27'd0, keep_q} > 32'(i));
    assign le_v[i]   = add_fire && active[i] && cell_le[i];
    if (i == 0) begin : g_head
      assign hit_above[i] = 1'b0;
    end else begin : g_body
      assign hit_above[i] = hit_above[i-1] | le_v[i-1];
    end
    assign first[i]              = le_v[i] && !hit_above[i];
    assign cell_ctrl[i].load_new  = first[i];
    assign cell_ctrl[i].load_prev = active[i] && hit_above[i];

    if (i == 0) begin : g_first
      tkst_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (cell_ctrl[i]),
        .new_score_i  (in_score),
        .new_tag_i    (in_tag),
        .prev_score_i ('0),
        .prev_tag_i   ('0),
        .score_o      (cell_score[i]),
        .tag_o        (cell_tag[i]),
        .le_o         (cell_le[i]),
        .gt_o         (cell_gt[i])
      );
    end else begin : g_rest
      tkst_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (cell_ctrl[i]),
        .new_score_i  (in_score),
        .new_tag_i    (in_tag),
        .prev_score_i (cell_score[i-1]),
        .prev_tag_i   (cell_tag[i-1]),
        .score_o      (cell_score[i]),
        .tag_o        (cell_tag[i]),
        .le_o         (cell_le[i]),
        .gt_o         (cell_gt[i])
      );
    end
  end

  // result assembly
  always_comb begin
    prank_full = '0;
    res_es     = '0;
    res_tag    = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      if (first[i]) begin
        prank_full = prank_full | 32'(i);
      end
      if ((op == tkst_pkg::OP_READ) && ({28'd0, in_rank} == 32'(i))) begin
        res_es  = cell_score[i];
        res_tag = cell_tag[i];
      end
    end
    res_placed = |le_v;
    res_prank  = prank_full[3:0];
    res_qual   = (op == tkst_pkg::OP_QUERY) && |(active & cell_gt);
    res_best   = first[0] ? in_score : cell_score[0];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= {res_best, res_tag[7:0], res_tag[15:8], res_tag[23:16], res_es,
                     res_prank, res_placed, res_qual};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_data_q};

endmodule

// ===== src/tkst_cell.sv =====
`timescale 1ns / 1ps
module tkst_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tkst_pkg::cell_ctrl_t              ctrl_i,
  input  logic [tkst_pkg::SCORE_W-1:0]      new_score_i,
  input  logic [tkst_pkg::TAG_W-1:0]        new_tag_i,
  input  logic [tkst_pkg::SCORE_W-1:0]      prev_score_i,
  input  logic [tkst_pkg::TAG_W-1:0]        prev_tag_i,
  output logic [tkst_pkg::SCORE_W-1:0]      score_o,
  output logic [tkst_pkg::TAG_W-1:0]        tag_o,
  output logic                              le_o,
  output logic                              gt_o
);

  logic [tkst_pkg::SCORE_W-1:0] score_q, score_d;
  logic [tkst_pkg::TAG_W-1:0]   tag_q, tag_d;

  // local compares against the incoming score
  assign le_o = (score_q <= new_score_i);
  assign gt_o = (new_score_i > score_q);

  // take the new record, the upper neighbor's record, or hold
  always_comb begin
    score_d = score_q;
    tag_d   = tag_q;
    if (ctrl_i.load_new) begin
      score_d = new_score_i;
      tag_d   = new_tag_i;
    end else if (ctrl_i.load_prev) begin
      score_d = prev_score_i;
      tag_d   = prev_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q <= '0;
      tag_q   <= tkst_pkg::TAG_RESET;
    end else begin
      score_q <= score_d;
      tag_q   <= tag_d;
    end
  end

  assign score_o = score_q;
  assign tag_o   = tag_q;

endmodule

// ===== src/tkst_checker.sv =====
`timescale 1ns / 1ps
module tkst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [63:0] s_axis_tdata_i,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [95:0] m_axis_tdata_o
);

  logic in_fire;
  logic add_fire;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign add_fire = in_fire && (s_axis_tuser_i == tkst_pkg::OP_ADD);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output transaction changed while stalled");

  // every accepted transaction shows a result the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> m_axis_tvalid_o)
    else $error("no result after accepted transaction");

  // qualifies and placed never come from the same transaction
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))
    else $error("qualifies and placed both set");

  // after an add the best score is never below the added score
  a_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_fire |=> m_axis_tdata_o[93:62] >= $past(s_axis_tdata_i[31:0]))
    else $error("best score below added score");

  // an add reports no entry contents
  a_add_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_fire |=> m_axis_tdata_o[61:6] == 56'd0)
    else $error("add transaction carried entry fields");

endmodule

bind top_k_score_table_top tkst_checker u_tkst_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== tb/sv/score_table_checker.sv =====
`timescale 1ns / 1ps
module score_table_checker
  import tkst_pkg::*;
#(
  parameter int unsigned MaxEntries = MAX_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] in_data_i,
  input  logic [1:0]  in_user_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [95:0] out_data_i,
  output int          outstanding_o,
  output int          mismatch_count_o
);

  typedef struct packed {
    logic        qualifies;
    logic        placed;
    logic [3:0]  placed_rank;
    logic [31:0] entry_score;
    logic [7:0]  entry_tag_first;
    logic [7:0]  entry_tag_second;
    logic [7:0]  entry_tag_third;
    logic [31:0] best_score;
  } table_result_t;

  // shadow copy of the ranked table
  logic [SCORE_W-1:0] rank_score[MaxEntries];
  logic [TAG_W-1:0]   rank_tag[MaxEntries];
  logic [KEEP_W-1:0]  keep_reg;

  table_result_t predicted_results[$];
  table_result_t got, want;
  int            mismatches = 0;

  assign mismatch_count_o = mismatches;

  // apply one transaction to the shadow table and work out its result
  task automatic apply_to_table(input op_e op, input logic [31:0] score,
                                input logic [23:0] tag, input logic [3:0] rank,
                                output table_result_t res);
    int  active;
    int  pos;
    bit  found;
    active = (keep_reg == 0) ? 1 : (keep_reg > MaxEntries) ? MaxEntries : keep_reg;
    res    = '0;
    found  = 1'b0;
    case (op)
      OP_ADD: begin
        // new record goes ahead of the first entry that is equal or lower
        pos = active;
        for (int i = 0; i < active; i++) begin
          if (!found && rank_score[i] <= score) begin
            pos   = i;
            found = 1'b1;
          end
        end
        if (found) begin
          for (int i = active - 1; i > pos; i--) begin
            rank_score[i] = rank_score[i-1];
            rank_tag[i]   = rank_tag[i-1];
          end
          rank_score[pos] = score;
          rank_tag[pos]   = tag;
          res.placed      = 1'b1;
          res.placed_rank = 4'(pos);
        end
      end
      OP_QUERY: begin
        for (int i = 0; i < active; i++) begin
          if (score > rank_score[i]) res.qualifies = 1'b1;
        end
      end
      OP_READ: begin
        // ranks past the active count still read the stored contents
        if (rank < MaxEntries) begin
          res.entry_score      = rank_score[rank];
          res.entry_tag_first  = rank_tag[rank][23:16];
          res.entry_tag_second = rank_tag[rank][15:8];
          res.entry_tag_third  = rank_tag[rank][7:0];
        end
      end
      default: ;
    endcase
    res.best_score = rank_score[0];
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // observe transactions, compare outputs first, then predict new inputs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxEntries; i++) begin
        rank_score[i] = '0;
        rank_tag[i]   = TAG_RESET;
      end
      keep_reg = KEEP_RESET;
      predicted_results.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) keep_reg = cfg_wdata_i;

      if (out_valid_i && out_ready_i) begin
        got = {out_data_i[0], out_data_i[1], out_data_i[5:2], out_data_i[37:6],
               out_data_i[45:38], out_data_i[53:46], out_data_i[61:54], out_data_i[93:62]};
        if (predicted_results.size() == 0) begin
          $error("output transaction with no prediction pending");
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          check_field("qualifies", 32'(want.qualifies), 32'(got.qualifies));
          check_field("placed", 32'(want.placed), 32'(got.placed));
          check_field("placed_rank", 32'(want.placed_rank), 32'(got.placed_rank));
          check_field("entry_score", want.entry_score, got.entry_score);
          check_field("entry_tag_first", 32'(want.entry_tag_first),
                      32'(got.entry_tag_first));
          check_field("entry_tag_second", 32'(want.entry_tag_second),
                      32'(got.entry_tag_second));
          check_field("entry_tag_third", 32'(want.entry_tag_third),
                      32'(got.entry_tag_third));
          check_field("best_score", want.best_score, got.best_score);
        end
      end

      if (in_valid_i && in_ready_i) begin
        apply_to_table(op_e'(in_user_i), in_data_i[31:0],
                       {in_data_i[39:32], in_data_i[47:40], in_data_i[55:48]},
                       in_data_i[59:56], want);
        predicted_results.insert(predicted_results.size(), want);
      end

      outstanding_o <= predicted_results.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import tkst_pkg::*;

  localparam int QuietLimit = 2000;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        s_valid   = 1'b0;
  logic [63:0] s_data    = '0;
  logic [1:0]  s_user    = '0;
  logic        m_ready   = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [95:0] m_axis_tdata_o;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int quiet_cycles    = 0;
  int outstanding;
  int mismatches;

  top_k_score_table_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  score_table_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (s_valid),
    .in_ready_i       (s_axis_tready_o),
    .in_data_i        (s_data),
    .in_user_i        (s_user),
    .out_valid_i      (m_axis_tvalid_o),
    .out_ready_i      (m_ready),
    .out_data_i       (m_axis_tdata_o),
    .outstanding_o    (outstanding),
    .mismatch_count_o (mismatches)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // random backpressure on the result side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // present one transaction, with random idle cycles ahead of it
  task automatic send_item(input op_e op, input logic [31:0] score, input logic [7:0] tag1,
                           input logic [7:0] tag2, input logic [7:0] tag3,
                           input logic [3:0] rank);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {4'b0, rank, tag3, tag2, tag1, score};
    s_user  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // hold off input until every predicted result has been drained
  task automatic wait_for_results();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic set_keep_count(input logic [4:0] value);
    wait_for_results();
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // scores cluster low and high so ties and full tables show up often
  function automatic logic [31:0] random_score();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 4) return 32'($urandom_range(15));
    if (pick < 6) return 32'hFFFF_FFFF - 32'($urandom_range(15));
    return $urandom;
  endfunction

  task automatic send_random_item();
    int unsigned pick;
    op_e         op;
    pick = $urandom_range(99);
    if (pick < 45) op = OP_ADD;
    else if (pick < 70) op = OP_QUERY;
    else if (pick < 95) op = OP_READ;
    else op = OP_NOP;
    send_item(op, random_score(), 8'($urandom), 8'($urandom), 8'($urandom),
              4'($urandom));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset contents, ties and extremes with the default count
    send_item(OP_READ, 32'd0, 8'h00, 8'h00, 8'h00, 4'd0);
    send_item(OP_READ, 32'd0, 8'h00, 8'h00, 8'h00, 4'd15);
    send_item(OP_QUERY, 32'd0, 8'h00, 8'h00, 8'h00, 4'd0);
    send_item(OP_QUERY, 32'd1, 8'h00, 8'h00, 8'h00, 4'd0);
    send_item(OP_ADD, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 4'd15);
    send_item(OP_ADD, 32'd0, 8'h00, 8'h00, 8'h00, 4'd0);
    send_item(OP_ADD, 32'd5, "B", "C", "D", 4'd0);
    send_item(OP_ADD, 32'd5, "E", "F", "G", 4'd0);
    send_item(OP_READ, 32'd0, 8'h00, 8'h00, 8'h00, 4'd1);
    send_item(OP_READ, 32'd0, 8'h00, 8'h00, 8'h00, 4'd2);
    send_item(OP_QUERY, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 4'd0);
    send_item(OP_NOP, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 4'd15);
    send_item(OP_ADD, 32'h8000_0000, 8'h5A, 8'hA5, 8'h3C, 4'd9);
    send_item(OP_READ, 32'd0, 8'h00, 8'h00, 8'h00, 4'd9);

    // single active entry holding the top score: adds below it are dropped
    set_keep_count(5'd1);
    send_item(OP_ADD, 32'd7, "X", "Y", "Z", 4'd0);
    send_item(OP_QUERY, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 4'd0);
    send_item(OP_READ, 32'd0, 8'h00, 8'h00, 8'h00, 4'd3);
    send_item(OP_ADD, 32'hFFFF_FFFF, "T", "O", "P", 4'd0);

    // zero count behaves as one
    set_keep_count(5'd0);
    send_item(OP_ADD, 32'd3, 8'h11, 8'h22, 8'h33, 4'd0);
    send_item(OP_QUERY, 32'hFFFF_FFFE, 8'h00, 8'h00, 8'h00, 4'd0);

    // oversize count behaves as the full table
    set_keep_count(5'd31);
    send_item(OP_ADD, 32'd1, 8'h44, 8'h55, 8'h66, 4'd0);
    send_item(OP_READ, 32'd0, 8'h00, 8'h00, 8'h00, 4'd15);

    // random phases over counts and idle patterns
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       set_keep_count(5'd16);
        1:       set_keep_count(5'd3);
        2:       set_keep_count(5'd31);
        3:       set_keep_count(5'd0);
        4:       set_keep_count(5'd10);
        default: set_keep_count(5'($urandom_range(2, 15)));
      endcase
      case (p % 4)
        0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin sender_idle_pct = 79; recv_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin sender_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int n = 0; n < 190; n++) begin
        if (n == 95) wait_for_results();
        send_random_item();
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tkst_pkg.sv
src/tkst_cell.sv
src/top_k_score_table_top.sv
src/tkst_checker.sv
tb/sv/score_table_checker.sv
tb/sv/tb_top.sv
